### design/udpc_pkg.sv
// Package for the UDP datagram checker: constants, error codes, beat and
// result structs, and the ones' complement add helper.
// No dependencies.
package udpc_pkg;

  // Longest datagram counted; longer streams are flagged oversize
  localparam int unsigned MAX_PACKET_BYTES = 65535;
  localparam int unsigned HDR_BYTES        = 8;
  localparam logic [15:0] UDP_PROTOCOL     = 16'd17;
  localparam logic [15:0] SUM_ALL_ONES     = 16'hffff;

  // Byte count, one bit wider than the limit so it can saturate above it
  typedef logic [16:0] count_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_RUNT     = 3'd1,
    ERR_SRC_PORT = 3'd2,
    ERR_DST_PORT = 3'd3,
    ERR_LENGTH   = 3'd4,
    ERR_CHECKSUM = 3'd5,
    ERR_OVERSIZE = 3'd6
  } err_t;

  // One registered input beat
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        first_byte;
    logic [31:0] ip_source;
    logic [31:0] ip_destination;
  } beat_t;

  // Datagram state captured on its last byte
  typedef struct packed {
    count_t      byte_count;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] length_field;
    logic [15:0] checksum_field;
    logic [15:0] sum;
    logic [7:0]  pending_high_byte;
  } snap_t;

  typedef struct packed {
    logic        accepted;
    err_t        error_code;
    logic [15:0] port_source;
    logic [15:0] port_destination;
    logic [15:0] payload_bytes;
  } result_t;

  // 16-bit end-around-carry add; the result stays congruent mod 0xffff
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

### design/udpc_if.sv
// Valid/ready channel interfaces for the UDP datagram checker: byte input
// and verdict output. No dependencies.
interface udpc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        first_byte;
  logic [31:0] ip_source;
  logic [31:0] ip_destination;

  modport source(output valid, data_byte, last_byte, first_byte, ip_source,
                 ip_destination, input ready);
  modport sink(input valid, data_byte, last_byte, first_byte, ip_source,
               ip_destination, output ready);
endinterface

interface udpc_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [2:0]  error_code;
  logic [15:0] port_source;
  logic [15:0] port_destination;
  logic [15:0] payload_bytes;

  modport source(output valid, accepted, error_code, port_source,
                 port_destination, payload_bytes, input ready);
  modport sink(input valid, accepted, error_code, port_source,
               port_destination, payload_bytes, output ready);
endinterface

### design/udp_datagram_checker.sv
// Top level of the UDP datagram checker: input register, accumulator,
// verdict register and output register. Depends on udpc_pkg, udpc_if,
// udpc_accum and udpc_verdict.
//
// Takes one datagram byte per clock, unless a stalled verdict backs up the
// stages; no gaps are required between bytes or datagrams. A datagram's last
// byte passes from the input register to the capture register, and its
// verdict is held in the result register, which drives the output. Bytes
// keep flowing while a verdict waits to be taken, until a second finished
// datagram is captured. The running sum is a 16-bit end-around-carry sum,
// each byte pair added when its low byte arrives. Verdicts apply this
// priority: oversize (more than 65535 bytes), runt (fewer than 8), zero source
// port, zero destination port, bad length, checksum. A zero checksum field skips the checksum test.
module udp_datagram_checker (
  input  logic       clk,
  input  logic       rst,
  udpc_in_if.sink    datagram,
  udpc_out_if.source verdict
);

  logic               s1_valid;
  udpc_pkg::beat_t    s1_beat;
  logic               snap_valid;
  udpc_pkg::snap_t    snap_q;
  udpc_pkg::snap_t    snap_d;
  logic               out_valid;
  udpc_pkg::result_t  out_q;
  udpc_pkg::result_t  result_d;
  udpc_pkg::count_t   byte_count;

  logic out_free;
  logic snap_free;
  logic step;
  logic take;

  // Stage advance: each stage moves when the one after it has room
  assign out_free       = !out_valid || verdict.ready;
  assign snap_free      = !snap_valid || out_free;
  assign step           = s1_valid && snap_free;
  assign datagram.ready = !s1_valid || snap_free;
  assign take           = datagram.valid && datagram.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (datagram.ready) begin
      s1_valid <= datagram.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_beat.data_byte      <= datagram.data_byte;
      s1_beat.last_byte      <= datagram.last_byte;
      s1_beat.first_byte     <= datagram.first_byte;
      s1_beat.ip_source      <= datagram.ip_source;
      s1_beat.ip_destination <= datagram.ip_destination;
    end
  end

  udpc_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .beat       (s1_beat),
    .snap       (snap_d),
    .byte_count (byte_count)
  );

  // Capture register for a finished datagram
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_free) begin
      snap_valid <= step && s1_beat.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_beat.last_byte) begin
      snap_q <= snap_d;
    end
  end

  udpc_verdict u_verdict (
    .snap   (snap_q),
    .result (result_d)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && out_free) begin
      out_q <= result_d;
    end
  end

  assign verdict.valid            = out_valid;
  assign verdict.accepted         = out_q.accepted;
  assign verdict.error_code       = 3'(out_q.error_code);
  assign verdict.port_source      = out_q.port_source;
  assign verdict.port_destination = out_q.port_destination;
  assign verdict.payload_bytes    = out_q.payload_bytes;

  // A new verdict only follows a captured datagram
  a_out_from_snap: assert property (@(posedge clk) disable iff (rst)
    (out_free && !snap_valid) |=> !out_valid)
    else $error("verdict shown without a captured datagram");

  // The count never passes one above the limit
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    byte_count <= 17'(udpc_pkg::MAX_PACKET_BYTES + 1))
    else $error("byte count beyond saturation");

  // Last byte processed returns the count to zero
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    (step && s1_beat.last_byte) |=> (byte_count == '0))
    else $error("byte count not cleared after last byte");

  // Accepted flag agrees with the error code
  a_accept_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_q.accepted == (out_q.error_code == udpc_pkg::ERR_NONE)))
    else $error("accepted flag disagrees with error code");

endmodule

### design/udpc_accum.sv
// Per-byte datagram state: header capture, byte count and running ones'
// complement sum. Depends on udpc_pkg.
module udpc_accum (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  udpc_pkg::beat_t  beat,
  output udpc_pkg::snap_t  snap,
  output udpc_pkg::count_t byte_count
);

  udpc_pkg::count_t byte_index, byte_index_next;
  logic [15:0] src_port, src_port_next;
  logic [15:0] dst_port, dst_port_next;
  logic [15:0] len_field, len_field_next;
  logic [15:0] ck_field, ck_field_next;
  logic [15:0] sum, sum_next;
  logic [7:0]  pending, pending_next;

  logic             start;
  udpc_pkg::count_t idx;
  logic             in_header;
  logic             do_sum;
  logic [15:0]      base_src, base_dst, base_len, base_ck, base_sum;
  logic [15:0]      pseudo_sum;

  // Pseudo header: both addresses and the protocol number
  assign pseudo_sum = udpc_pkg::ones_add(
      udpc_pkg::ones_add(udpc_pkg::ones_add(beat.ip_source[31:16], beat.ip_source[15:0]),
                         udpc_pkg::ones_add(beat.ip_destination[31:16],
                                            beat.ip_destination[15:0])),
      udpc_pkg::UDP_PROTOCOL);

  // A first mark, or any byte while idle, opens a new datagram
  always_comb begin
    start     = beat.first_byte || (byte_index == '0);
    idx       = start ? '0 : byte_index;
    base_src  = start ? '0 : src_port;
    base_dst  = start ? '0 : dst_port;
    base_len  = start ? '0 : len_field;
    base_ck   = start ? '0 : ck_field;
    base_sum  = start ? pseudo_sum : sum;
    in_header = idx < 17'(udpc_pkg::HDR_BYTES);

    src_port_next = base_src;
    dst_port_next = base_dst;
    len_field_next = base_len;
    ck_field_next = base_ck;
    if (in_header) begin
      case (idx[2:0])
        3'd0: src_port_next = {beat.data_byte, 8'd0};
        3'd1: src_port_next = base_src | {8'd0, beat.data_byte};
        3'd2: dst_port_next = {beat.data_byte, 8'd0};
        3'd3: dst_port_next = base_dst | {8'd0, beat.data_byte};
        3'd4: len_field_next = {beat.data_byte, 8'd0};
        3'd5: len_field_next = base_len | {8'd0, beat.data_byte};
        3'd6: ck_field_next = {beat.data_byte, 8'd0};
        default: ck_field_next = base_ck | {8'd0, beat.data_byte};
      endcase
    end

    // Sum header bytes and bytes inside the length field, below the limit, paired high then low
    do_sum = (idx < 17'(udpc_pkg::MAX_PACKET_BYTES)) &&
             (in_header || (idx < {1'b0, base_len}));
    pending_next = pending;
    sum_next     = base_sum;
    if (do_sum) begin
      if (!idx[0]) begin
        pending_next = beat.data_byte;
      end else begin
        sum_next = udpc_pkg::ones_add(base_sum, {pending, beat.data_byte});
      end
    end

    // Count saturates one above the limit
    byte_index_next = (idx <= 17'(udpc_pkg::MAX_PACKET_BYTES)) ? idx + 17'd1 : idx;

    snap.byte_count        = byte_index_next;
    snap.src_port          = src_port_next;
    snap.dst_port          = dst_port_next;
    snap.length_field      = len_field_next;
    snap.checksum_field    = ck_field_next;
    snap.sum               = sum_next;
    snap.pending_high_byte = pending_next;
  end

  // Count returns to zero after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
    end else if (step) begin
      byte_index <= beat.last_byte ? '0 : byte_index_next;
    end
  end

  // Header fields and sum
  always_ff @(posedge clk) begin
    if (step) begin
      src_port  <= src_port_next;
      dst_port  <= dst_port_next;
      len_field <= len_field_next;
      ck_field  <= ck_field_next;
      sum       <= sum_next;
      pending   <= pending_next;
    end
  end

  assign byte_count = byte_index;

endmodule

### design/udpc_verdict.sv
// Verdict decode for one finished datagram: error priority, checksum fold
// and payload length. Depends on udpc_pkg.
module udpc_verdict (
  input  udpc_pkg::snap_t   snap,
  output udpc_pkg::result_t result
);

  logic [15:0]     pad;
  logic [15:0]     folded;
  logic            sum_ok;
  udpc_pkg::err_t  code;

  // Add the length field and the zero-padded odd byte, then test the fold
  always_comb begin
    pad    = snap.length_field[0] ? {snap.pending_high_byte, 8'd0} : 16'd0;
    folded = udpc_pkg::ones_add(udpc_pkg::ones_add(snap.sum, snap.length_field), pad);
    sum_ok = (folded == udpc_pkg::SUM_ALL_ONES) || (folded == 16'd0);
  end

  // Checks in priority order
  always_comb begin
    if (snap.byte_count > 17'(udpc_pkg::MAX_PACKET_BYTES)) begin
      code = udpc_pkg::ERR_OVERSIZE;
    end else if (snap.byte_count < 17'(udpc_pkg::HDR_BYTES)) begin
      code = udpc_pkg::ERR_RUNT;
    end else if (snap.src_port == 16'd0) begin
      code = udpc_pkg::ERR_SRC_PORT;
    end else if (snap.dst_port == 16'd0) begin
      code = udpc_pkg::ERR_DST_PORT;
    end else if ((snap.length_field < 16'(udpc_pkg::HDR_BYTES)) ||
                 ({1'b0, snap.length_field} > snap.byte_count)) begin
      code = udpc_pkg::ERR_LENGTH;
    end else if ((snap.checksum_field != 16'd0) && !sum_ok) begin
      code = udpc_pkg::ERR_CHECKSUM;
    end else begin
      code = udpc_pkg::ERR_NONE;
    end

    result.accepted         = (code == udpc_pkg::ERR_NONE);
    result.error_code       = code;
    result.port_source      = snap.src_port;
    result.port_destination = snap.dst_port;
    result.payload_bytes    = (code == udpc_pkg::ERR_NONE) ?
                              snap.length_field - 16'(udpc_pkg::HDR_BYTES) : 16'd0;
  end

endmodule
